@@ hw/rtl/h2r_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h2r_pkg
// Types, fixed-point constants and the hue segment function shared by the
// HSL to RGB converter.
// ----------------------------------------------------------------------------
package h2r_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = FRAC_BITS + 1;      // input fraction, 0..1.0
  localparam int U_W       = FRAC_BITS + 4;      // six times hue, plus offset
  localparam int LS_W      = 2 * IN_W;           // l * s product
  localparam int Q_W       = 2 * FRAC_BITS + 2;  // q before the shift
  localparam int C_W       = 2 * FRAC_BITS + 1;  // channel value, 0..ONE^2

  localparam logic [IN_W-1:0] ONE  = IN_W'(1) << FRAC_BITS;
  localparam logic [IN_W-1:0] HALF = IN_W'(1) << (FRAC_BITS - 1);

  localparam logic [U_W-1:0] ONE_U   = U_W'(1) << FRAC_BITS;
  localparam logic [U_W-1:0] TWO_U   = U_W'(2) << FRAC_BITS;
  localparam logic [U_W-1:0] THREE_U = U_W'(3) << FRAC_BITS;
  localparam logic [U_W-1:0] FOUR_U  = U_W'(4) << FRAC_BITS;
  localparam logic [U_W-1:0] SIX_U   = U_W'(6) << FRAC_BITS;

  // hue segment codes
  localparam logic [1:0] SEG_RISE = 2'd0;
  localparam logic [1:0] SEG_HIGH = 2'd1;
  localparam logic [1:0] SEG_FALL = 2'd2;
  localparam logic [1:0] SEG_LOW  = 2'd3;

  typedef struct packed {
    logic [IN_W-1:0] hue;
    logic [IN_W-1:0] saturation;
    logic [IN_W-1:0] lightness;
  } hsl_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [IN_W-1:0] p;
    logic [IN_W-1:0] q;
    logic [IN_W-1:0] d;
    logic [IN_W-1:0] l;
    logic            grey;
  } level_t;

  typedef struct packed {
    logic [1:0]      seg;
    logic [IN_W-1:0] x;
  } seg_x_t;

  typedef struct packed {
    logic s1;
    logic s2;
  } prep_en_t;

  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
  } chan_en_t;

  function automatic seg_x_t hue_segment(logic [U_W-1:0] u);
    seg_x_t r;
    r.x = '0;
    if (u < ONE_U) begin
      r.seg = SEG_RISE;
      r.x   = u[IN_W-1:0];
    end else if (u < THREE_U) begin
      r.seg = SEG_HIGH;
    end else if (u < FOUR_U) begin
      r.seg = SEG_FALL;
      r.x   = IN_W'(FOUR_U - u);
    end else begin
      r.seg = SEG_LOW;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/h2r_prep.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h2r_prep
// Stages 1-2: input clamp, l*s product and hue offsets, then q, p, q-p and
// the hue segment of each channel.
// ----------------------------------------------------------------------------
module h2r_prep
  import h2r_pkg::*;
(
  input  wire logic     clk,
  input  wire prep_en_t en,
  input  wire hsl_t     hsl,
  output level_t        level,
  output seg_x_t        seg_r,
  output seg_x_t        seg_g,
  output seg_x_t        seg_b
);

  logic [IN_W-1:0] hc, sc, lc;
  logic [U_W-1:0]  u, ur_sum, ur_next, ub_next;

  logic [IN_W-1:0] l1, s1;
  logic [LS_W-1:0] ls1;
  logic            grey1;
  logic [U_W-1:0]  ur1, ug1, ub1;

  logic [Q_W-1:0]  q2;
  logic [IN_W-1:0] q_next, p_next;
  logic [IN_W:0]   p_wide;

  always_comb begin
    hc = (hsl.hue        > ONE) ? ONE : hsl.hue;
    sc = (hsl.saturation > ONE) ? ONE : hsl.saturation;
    lc = (hsl.lightness  > ONE) ? ONE : hsl.lightness;
    u  = (U_W'(hc) << 2) + (U_W'(hc) << 1);
    ur_sum  = u + TWO_U;
    ur_next = (ur_sum > SIX_U) ? ur_sum - SIX_U : ur_sum;
    ub_next = (u < TWO_U) ? u + FOUR_U : u - TWO_U;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      l1    <= lc;
      s1    <= sc;
      ls1   <= LS_W'(lc) * LS_W'(sc);
      grey1 <= (sc == '0);
      ur1   <= ur_next;
      ug1   <= u;
      ub1   <= ub_next;
    end
  end

  always_comb begin
    if (l1 < HALF) begin
      q2 = (Q_W'(l1) << FRAC_BITS) + Q_W'(ls1);
    end else begin
      q2 = ((Q_W'(l1) + Q_W'(s1)) << FRAC_BITS) - Q_W'(ls1);
    end
    q_next = q2[FRAC_BITS+IN_W-1:FRAC_BITS];
    p_wide = {l1, 1'b0} - {1'b0, q_next};
    p_next = p_wide[IN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      level.p    <= p_next;
      level.q    <= q_next;
      level.d    <= q_next - p_next;
      level.l    <= l1;
      level.grey <= grey1;
      seg_r      <= hue_segment(ur1);
      seg_g      <= hue_segment(ug1);
      seg_b      <= hue_segment(ub1);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/h2r_channel.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h2r_channel
// Stages 3-5 of one color channel: ramp product, channel value, scale by 255
// with truncate and clamp, grey select.
// ----------------------------------------------------------------------------
module h2r_channel
  import h2r_pkg::*;
(
  input  wire logic     clk,
  input  wire chan_en_t en,
  input  wire level_t   level,
  input  wire seg_x_t   seg_x,
  output logic [7:0]    byte_out
);

  logic [C_W-1:0]  prod3;
  logic [IN_W-1:0] p3, q3, l3;
  logic [1:0]      seg3;
  logic            grey3;

  logic [C_W-1:0]  c_next, c4;
  logic [IN_W-1:0] l4;
  logic            grey4;

  logic [C_W+7:0]  c_scaled;
  logic [IN_W+7:0] g_scaled;
  logic [8:0]      c_byte, g_byte;
  logic [7:0]      byte_next;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      prod3 <= C_W'(level.d) * C_W'(seg_x.x);
      p3    <= level.p;
      q3    <= level.q;
      l3    <= level.l;
      seg3  <= seg_x.seg;
      grey3 <= level.grey;
    end
  end

  always_comb begin
    unique case (seg3)
      SEG_RISE, SEG_FALL: c_next = (C_W'(p3) << FRAC_BITS) + prod3;
      SEG_HIGH:           c_next = C_W'(q3) << FRAC_BITS;
      default:            c_next = C_W'(p3) << FRAC_BITS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      c4    <= c_next;
      l4    <= l3;
      grey4 <= grey3;
    end
  end

  always_comb begin
    c_scaled  = {c4, 8'd0} - {8'd0, c4};
    g_scaled  = {l4, 8'd0} - {8'd0, l4};
    c_byte    = c_scaled[C_W+7:2*FRAC_BITS];
    g_byte    = g_scaled[IN_W+7:FRAC_BITS];
    if (grey4) begin
      byte_next = g_byte[8] ? 8'hFF : g_byte[7:0];
    end else begin
      byte_next = c_byte[8] ? 8'hFF : c_byte[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      byte_out <= byte_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/hsl_to_rgb_converter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Five register stages, each with its own valid bit, lie between an accepted
// input and rgb_valid. Throughput: one transaction per cycle while rgb_stall
// is low; the stall chain lets bubbles close up behind a stalled output.
// Reset: rst clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Converts hue, saturation and lightness fractions to red, green and blue
// bytes.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter
  import h2r_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic hsl_valid,
  output logic      hsl_stall,
  input  wire hsl_t hsl,
  output logic      rgb_valid,
  input  wire logic rgb_stall,
  output rgb_t      rgb
);

  logic [4:0] v;
  logic [4:0] en;
  prep_en_t   prep_en;
  chan_en_t   chan_en;
  level_t     level;
  seg_x_t     seg_r, seg_g, seg_b;

  always_comb begin
    en[4] = !v[4] || !rgb_stall;
    en[3] = !v[3] || en[4];
    en[2] = !v[2] || en[3];
    en[1] = !v[1] || en[2];
    en[0] = !v[0] || en[1];
    prep_en.s1 = en[0];
    prep_en.s2 = en[1];
    chan_en.s3 = en[2];
    chan_en.s4 = en[3];
    chan_en.s5 = en[4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= hsl_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
      if (en[4]) v[4] <= v[3];
    end
  end

  assign hsl_stall = !en[0];
  assign rgb_valid = v[4];

  h2r_prep u_prep (
    .clk   (clk),
    .en    (prep_en),
    .hsl   (hsl),
    .level (level),
    .seg_r (seg_r),
    .seg_g (seg_g),
    .seg_b (seg_b)
  );

  h2r_channel u_red (
    .clk      (clk),
    .en       (chan_en),
    .level    (level),
    .seg_x    (seg_r),
    .byte_out (rgb.red)
  );

  h2r_channel u_green (
    .clk      (clk),
    .en       (chan_en),
    .level    (level),
    .seg_x    (seg_g),
    .byte_out (rgb.green)
  );

  h2r_channel u_blue (
    .clk      (clk),
    .en       (chan_en),
    .level    (level),
    .seg_x    (seg_b),
    .byte_out (rgb.blue)
  );

endmodule
`default_nettype wire
